>>> hw/rtl/sspr_pkg.sv
// ============================================================================
// sspr_pkg
// Shared codes, constants and types of the servo status packet receiver.
// ============================================================================
`default_nettype none

package sspr_pkg;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_RX_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    localparam int OUTQ_DEPTH = 3;
    localparam int PBUF_DEPTH = 512;

    typedef struct packed {
        logic       report_kind;
        logic [7:0] packet_id;
        logic [7:0] error_bits;
        logic [1:0] packet_status;
        logic       stored_flag;
        logic [3:0] pending_slots;
        logic [7:0] data_byte;
        logic       slot_answered;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic       bank;
        logic [7:0] slot;
        logic [7:0] start;
        logic [7:0] count;
    } copy_req_t;

    typedef struct packed {
        logic copy_busy;
        logic clearing;
    } writer_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/sspr_ram.sv
// ============================================================================
// sspr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module sspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sspr_writer.sv
// ============================================================================
// sspr_writer
// Table write engine: clearing sweep after reset and parameter copy from the
// packet buffer into a slot's table region, one byte per cycle.
// ============================================================================
`default_nettype none

module sspr_writer import sspr_pkg::*; #(
    parameter int ID_SLOTS    = 8,
    parameter int TABLE_BYTES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  copy_req_t      req,
    output logic [8:0]     buf_raddr,
    input  logic [7:0]     buf_rdata,
    output logic           tbl_we,
    output logic [$clog2(ID_SLOTS * (2 ** $clog2(TABLE_BYTES)))-1:0] tbl_waddr,
    output logic [7:0]     tbl_wdata,
    output writer_status_t status
);

    localparam int SW        = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
    localparam int AW        = $clog2(TABLE_BYTES);
    localparam int TBL_DEPTH = ID_SLOTS * (2 ** AW);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic              act_reg, act_next;
    logic              wp_reg;
    logic              clr_reg, clr_next;
    logic [TBL_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [7:0]        k_reg, k_next;
    logic              bank_reg;
    logic [SW-1:0]     slot_reg;
    logic [7:0]        start_reg;
    logic [7:0]        cnt_reg;
    logic [8:0]        wa_reg;
    logic [SW-1:0]     req_slot;
    logic [SW+AW-1:0]  copy_addr;

    assign req_slot = req.slot[SW-1:0];

    always_comb
    begin
        act_next = act_reg;
        k_next   = k_reg;
        if (act_reg)
        begin
            k_next = k_reg + 8'd1;
            if (8'(k_reg + 8'd1) == cnt_reg)
            begin
                act_next = 1'b0;
            end
        end
        if (req.valid)
        begin
            k_next   = 8'd0;
            act_next = (req.count != 8'd0);
        end

        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == TBL_AW'(TBL_DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg     <= 1'b0;
            wp_reg      <= 1'b0;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            k_reg       <= 8'd0;
        end
        else
        begin
            act_reg     <= act_next;
            wp_reg      <= act_reg;
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            bank_reg  <= req.bank;
            slot_reg  <= req_slot;
            start_reg <= req.start;
            cnt_reg   <= req.count;
        end
        wa_reg <= {1'b0, start_reg} + {1'b0, k_reg};
    end

    assign buf_raddr = {bank_reg, k_reg};
    assign copy_addr = {slot_reg, wa_reg[AW-1:0]};

    assign tbl_we    = clr_reg || (wp_reg && (wa_reg < 9'(TABLE_BYTES)));
    assign tbl_waddr = clr_reg ? clr_idx_reg : copy_addr[TBL_AW-1:0];
    assign tbl_wdata = clr_reg ? 8'h00 : buf_rdata;

    assign status.copy_busy = act_reg || wp_reg;
    assign status.clearing  = clr_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sspr_outq.sv
// ============================================================================
// sspr_outq
// Small result queue in front of the master-side stream.
// ============================================================================
`default_nettype none

module sspr_outq import sspr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  result_t    wr_data,
    output logic       out_valid,
    output result_t    out_data,
    input  logic       out_ready,
    output logic [1:0] count
);

    result_t    ent_reg [OUTQ_DEPTH];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = ent_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign count     = cnt_reg;

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (wr_en)
        begin
            wp_next = (wp_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wp_reg + 2'd1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rp_reg + 2'd1;
        end
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/servo_status_packet_receiver_top.sv
// ============================================================================
// servo_status_packet_receiver_top
// Status packet parser with per-slot control-table copies in block RAM.
// ============================================================================
// Each slave-side beat carries one operation: register an expected slot,
// one received bus byte, read back one table byte, or clear expectations.
// Bus bytes are parsed one per beat; a finished packet or a table read
// gives one master-side beat, held in a result register and then the
// output queue. The block takes one beat per cycle while tready is high.
// After a good packet from an expected slot its parameters are copied
// from the packet buffer into the table RAM at one byte per cycle. Bytes
// of the next packet are taken during the copy; a table read or a
// checksum byte waits until the copy is done.
// After reset a sweep zeroes all ID_SLOTS times TABLE_BYTES rounded up
// to a power of two entries of the table RAM (2048 by default) with
// tready low. When the receiver stalls, up to three results queue and
// then tready drops until a result leaves the queue.
// ============================================================================
`default_nettype none

module servo_status_packet_receiver_top import sspr_pkg::*; #(
    parameter int ID_SLOTS    = 8,
    parameter int TABLE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte, slot_id, table_address, zero fill
    input  logic [31:0] s_axis_tdata,
    // operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // packet_id, error_bits, packet_status, stored_flag, pending_slots,
    // data_byte, slot_answered
    output logic [31:0] m_axis_tdata,
    // report_kind
    output logic [0:0]  m_axis_tuser
);

    localparam logic [2:0] PH_HEAD1 = 3'd0;
    localparam logic [2:0] PH_HEAD2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_ERR   = 3'd4;
    localparam logic [2:0] PH_PARAM = 3'd5;
    localparam logic [2:0] PH_SUM   = 3'd6;

    localparam int SW        = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
    localparam int AW        = $clog2(TABLE_BYTES);
    localparam int TBL_DEPTH = ID_SLOTS * (2 ** AW);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int PW        = $clog2(ID_SLOTS + 1);

    logic [1:0] op;
    logic [7:0] rx;
    logic [2:0] slot_id;
    logic [7:0] taddr;
    logic       acc;

    logic [2:0]          phase_reg, phase_next;
    logic [7:0]          cur_id_reg, cur_id_next;
    logic [7:0]          cur_len_reg, cur_len_next;
    logic [7:0]          cur_err_reg, cur_err_next;
    logic [7:0]          pcnt_reg, pcnt_next;
    logic [7:0]          sum_reg, sum_next;
    logic                fill_bank_reg, fill_bank_next;
    logic [PW-1:0]       pend_reg, pend_next;
    logic [ID_SLOTS-1:0] exp_reg, exp_next;
    logic [ID_SLOTS-1:0] ans_reg, ans_next;
    logic [7:0]          serr_reg [ID_SLOTS];
    logic [7:0]          serr_next [ID_SLOTS];
    logic [7:0]          start_reg [ID_SLOTS];
    logic [7:0]          start_next [ID_SLOTS];

    logic    p1_valid_reg;
    result_t p1_res_reg;
    logic    p1_rd_reg;

    logic [7:0]    sel8;
    logic [SW-1:0] rec_idx;
    logic          rec_ok;
    logic          rec_exp;
    logic          rec_ans;
    logic [7:0]    rec_err;
    logic [7:0]    rec_start;
    logic [7:0]    sum_add;
    logic          good;
    logic          stored_now;
    logic          emit;
    logic          rd_from_ram;
    result_t       res;
    logic [7:0]    pend8;
    copy_req_t     copy_req;
    logic          pbuf_we;

    writer_status_t    wstat;
    logic [8:0]        pbuf_raddr;
    logic [7:0]        pbuf_rdata;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [7:0]        tbl_wdata;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [7:0]        tbl_rdata;
    logic [SW+AW-1:0]  read_full;
    logic [1:0]        q_count;
    result_t           q_wdata;
    result_t           q_out;
    logic              busy_block;
    logic              room;

    assign op      = s_axis_tuser;
    assign rx      = s_axis_tdata[7:0];
    assign slot_id = s_axis_tdata[10:8];
    assign taddr   = s_axis_tdata[18:11];

    assign sel8      = (op == OP_RX_BYTE) ? cur_id_reg : {5'b00000, slot_id};
    assign rec_idx   = sel8[SW-1:0];
    assign rec_ok    = ({1'b0, sel8} < 9'(ID_SLOTS));
    assign rec_exp   = exp_reg[rec_idx];
    assign rec_ans   = ans_reg[rec_idx];
    assign rec_err   = serr_reg[rec_idx];
    assign rec_start = start_reg[rec_idx];

    assign sum_add    = sum_reg + rx;
    assign good       = (rx == ~sum_reg);
    assign stored_now = rec_ok && good && rec_exp;

    assign busy_block = wstat.copy_busy &&
                        ((op == OP_READ) || ((op == OP_RX_BYTE) && (phase_reg == PH_SUM)));
    assign room       = (({1'b0, q_count} + {2'b00, p1_valid_reg}) < 3'(OUTQ_DEPTH));
    assign s_axis_tready = !wstat.clearing && room && !busy_block;
    assign acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        phase_next     = phase_reg;
        cur_id_next    = cur_id_reg;
        cur_len_next   = cur_len_reg;
        cur_err_next   = cur_err_reg;
        pcnt_next      = pcnt_reg;
        sum_next       = sum_reg;
        fill_bank_next = fill_bank_reg;
        pend_next      = pend_reg;
        exp_next       = exp_reg;
        ans_next       = ans_reg;
        serr_next      = serr_reg;
        start_next     = start_reg;
        emit           = 1'b0;
        rd_from_ram    = 1'b0;
        res            = '0;
        copy_req       = '0;
        pbuf_we        = 1'b0;

        if (acc)
        begin
            case (op)
                OP_REGISTER:
                begin
                    if (rec_ok)
                    begin
                        if (!(rec_exp && !rec_ans))
                        begin
                            pend_next = pend_reg + 1'b1;
                        end
                        exp_next[rec_idx]   = 1'b1;
                        ans_next[rec_idx]   = 1'b0;
                        serr_next[rec_idx]  = 8'h00;
                        start_next[rec_idx] = taddr;
                    end
                end
                OP_RX_BYTE:
                begin
                    case (phase_reg)
                        PH_HEAD1:
                        begin
                            phase_next = (rx == HEADER_BYTE) ? PH_HEAD2 : PH_HEAD1;
                        end
                        PH_HEAD2:
                        begin
                            phase_next = (rx == HEADER_BYTE) ? PH_ID : PH_HEAD1;
                        end
                        PH_ID:
                        begin
                            if (rx != HEADER_BYTE)
                            begin
                                cur_id_next = rx;
                                sum_next    = rx;
                                phase_next  = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            cur_len_next = rx;
                            sum_next     = sum_add;
                            if (rx < 8'd2)
                            begin
                                emit              = 1'b1;
                                res.report_kind   = KIND_PACKET;
                                res.packet_id     = cur_id_reg;
                                res.packet_status = ST_SHORT;
                                res.slot_answered = rec_ok && rec_ans;
                                phase_next        = PH_HEAD1;
                            end
                            else
                            begin
                                phase_next = PH_ERR;
                            end
                        end
                        PH_ERR:
                        begin
                            cur_err_next = rx;
                            sum_next     = sum_add;
                            pcnt_next    = 8'd0;
                            phase_next   = (cur_len_reg == 8'd2) ? PH_SUM : PH_PARAM;
                        end
                        PH_PARAM:
                        begin
                            pbuf_we   = 1'b1;
                            pcnt_next = pcnt_reg + 8'd1;
                            sum_next  = sum_add;
                            if (({1'b0, pcnt_reg} + 9'd3) >= {1'b0, cur_len_reg})
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SUM:
                        begin
                            emit              = 1'b1;
                            res.report_kind   = KIND_PACKET;
                            res.packet_id     = cur_id_reg;
                            res.error_bits    = cur_err_reg;
                            res.packet_status = good ? ST_GOOD : ST_CHECKSUM;
                            res.stored_flag   = stored_now;
                            res.slot_answered = rec_ok && (stored_now || rec_ans);
                            phase_next        = PH_HEAD1;
                            if (stored_now)
                            begin
                                copy_req.valid = 1'b1;
                                copy_req.bank  = fill_bank_reg;
                                copy_req.slot  = cur_id_reg;
                                copy_req.start = rec_start;
                                copy_req.count = cur_len_reg - 8'd2;
                                fill_bank_next = ~fill_bank_reg;
                                if (!rec_ans && (pend_reg != '0))
                                begin
                                    pend_next = pend_reg - 1'b1;
                                end
                                ans_next[rec_idx]  = 1'b1;
                                serr_next[rec_idx] = cur_err_reg;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HEAD1;
                        end
                    endcase
                end
                OP_READ:
                begin
                    emit              = 1'b1;
                    res.report_kind   = KIND_READ;
                    res.packet_id     = {5'b00000, slot_id};
                    res.error_bits    = rec_ok ? rec_err : 8'h00;
                    res.slot_answered = rec_ok && rec_ans;
                    rd_from_ram       = rec_ok && ({1'b0, taddr} < 9'(TABLE_BYTES));
                end
                OP_CLEAR:
                begin
                    exp_next  = '0;
                    pend_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        pend8             = 8'(pend_next);
        res.pending_slots = pend8[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD1;
            cur_id_reg    <= 8'd0;
            cur_len_reg   <= 8'd0;
            cur_err_reg   <= 8'd0;
            pcnt_reg      <= 8'd0;
            sum_reg       <= 8'd0;
            fill_bank_reg <= 1'b0;
            pend_reg      <= '0;
            exp_reg       <= '0;
            ans_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            for (int i = 0; i < ID_SLOTS; i++)
            begin
                serr_reg[i]  <= 8'd0;
                start_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            cur_id_reg    <= cur_id_next;
            cur_len_reg   <= cur_len_next;
            cur_err_reg   <= cur_err_next;
            pcnt_reg      <= pcnt_next;
            sum_reg       <= sum_next;
            fill_bank_reg <= fill_bank_next;
            pend_reg      <= pend_next;
            exp_reg       <= exp_next;
            ans_reg       <= ans_next;
            p1_valid_reg  <= emit;
            serr_reg      <= serr_next;
            start_reg     <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_res_reg <= res;
        p1_rd_reg  <= rd_from_ram;
    end

    assign read_full = {rec_idx, taddr[AW-1:0]};
    assign tbl_raddr = read_full[TBL_AW-1:0];

    sspr_ram #(
        .WIDTH (8),
        .DEPTH (PBUF_DEPTH)
    ) u_pbuf (
        .clk   (clk),
        .we    (pbuf_we),
        .waddr ({fill_bank_reg, pcnt_reg}),
        .wdata (rx),
        .raddr (pbuf_raddr),
        .rdata (pbuf_rdata)
    );

    sspr_ram #(
        .WIDTH (8),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sspr_writer #(
        .ID_SLOTS    (ID_SLOTS),
        .TABLE_BYTES (TABLE_BYTES)
    ) u_writer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (copy_req),
        .buf_raddr (pbuf_raddr),
        .buf_rdata (pbuf_rdata),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .status    (wstat)
    );

    always_comb
    begin
        q_wdata           = p1_res_reg;
        q_wdata.data_byte = p1_rd_reg ? tbl_rdata : 8'h00;
    end

    sspr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (p1_valid_reg),
        .wr_data   (q_wdata),
        .out_valid (m_axis_tvalid),
        .out_data  (q_out),
        .out_ready (m_axis_tready),
        .count     (q_count)
    );

    assign m_axis_tdata = {q_out.slot_answered, q_out.data_byte, q_out.pending_slots,
                           q_out.stored_flag, q_out.packet_status, q_out.error_bits,
                           q_out.packet_id};
    assign m_axis_tuser = q_out.report_kind;

    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(exp_reg & ~ans_reg) == int'(pend_reg))
        else $error("Pending count does not match expected unanswered slots.");

    a_copy_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        copy_req.valid |-> !wstat.copy_busy)
        else $error("Table copy started while a copy is still running.");

    a_read_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (op == OP_READ)) |-> !wstat.copy_busy)
        else $error("Table read accepted during a copy.");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        wstat.clearing |-> !s_axis_tready)
        else $error("Beat accepted during the clearing sweep.");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> (q_count < 2'(OUTQ_DEPTH)))
        else $error("Result queue overflow.");

endmodule

`default_nettype wire
